/* hw/rtl/rhsv_pkg.sv */
// Shared types and constants for the RGB to HSV pixel converter.
`default_nettype none

package rhsv_pkg;

   localparam int ChanW    = 8;
   localparam int XW       = 11;
   localparam int HueRemW  = 19;
   localparam int HueDenW  = 18;
   localparam int SatRemW  = 16;
   localparam int SatDenW  = 15;
   localparam int QuotW    = 8;

   typedef enum logic [1:0] {
      SECT_RED_HI = 2'd0,
      SECT_GREEN  = 2'd1,
      SECT_BLUE   = 2'd2,
      SECT_RED_LO = 2'd3
   } sector_type;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [ChanW-1:0] brightness;
      logic [ChanW-1:0] delta;
      logic [XW-1:0]    hue_x;
      logic             grey;
   } front_type;

   typedef struct packed {
      logic [HueRemW-1:0] hue_rem;
      logic [HueDenW-1:0] hue_den;
      logic [QuotW-1:0]   hue_q;
      logic [SatRemW-1:0] sat_rem;
      logic [SatDenW-1:0] sat_den;
      logic [QuotW-1:0]   sat_q;
      logic [ChanW-1:0]   brightness;
      logic               grey;
   } div_type;

endpackage

`default_nettype wire

/* hw/rtl/rhsv_req_if.sv */
// Request channel interface carrying one RGB pixel.
`default_nettype none

interface rhsv_req_if
   import rhsv_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ChanW-1:0] red;
   logic [ChanW-1:0] green;
   logic [ChanW-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rhsv_rsp_if.sv */
// Response channel interface carrying one HSV pixel.
`default_nettype none

interface rhsv_rsp_if
   import rhsv_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ChanW-1:0] hue;
   logic [ChanW-1:0] saturation;
   logic [ChanW-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

`default_nettype wire

/* hw/rtl/rhsv_front.sv */
// First stage: maximum, minimum, delta and the hue sector numerator.
`default_nettype none

module rhsv_front
   import rhsv_pkg::*;
   (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire pixel_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output front_type      out_data
   );

   logic              valid_ff;
   front_type         data_ff;
   front_type         data_in;
   logic [ChanW-1:0]  mx;
   logic [ChanW-1:0]  mn;
   logic [ChanW-1:0]  delta;
   sector_type        sector;
   logic signed [8:0] diff;
   logic [XW-1:0]     base;
   logic signed [12:0] x_s;

   always_comb begin
      mx = in_data.red;
      if (in_data.green > mx) begin
         mx = in_data.green;
      end
      if (in_data.blue > mx) begin
         mx = in_data.blue;
      end
      mn = in_data.red;
      if (in_data.green < mn) begin
         mn = in_data.green;
      end
      if (in_data.blue < mn) begin
         mn = in_data.blue;
      end
      delta = mx - mn;

      priority if (in_data.blue == mx) begin
         sector = SECT_BLUE;
      end else if (in_data.green == mx) begin
         sector = SECT_GREEN;
      end else if (in_data.green >= in_data.blue) begin
         sector = SECT_RED_HI;
      end else begin
         sector = SECT_RED_LO;
      end

      unique case (sector)
         SECT_BLUE: begin
            diff = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
            base = {1'b0, delta, 2'b00};
         end
         SECT_GREEN: begin
            diff = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
            base = {2'b00, delta, 1'b0};
         end
         SECT_RED_HI: begin
            diff = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
            base = '0;
         end
         default: begin
            diff = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
            base = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
         end
      endcase

      x_s = $signed({2'b00, base}) + $signed({{4{diff[8]}}, diff});

      data_in.brightness = mx;
      data_in.delta      = delta;
      data_in.hue_x      = x_s[XW-1:0];
      data_in.grey       = (delta == '0);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rhsv_prep.sv */
// Second stage: scaled dividends and aligned divisors for both divisions.
`default_nettype none

module rhsv_prep
   import rhsv_pkg::*;
   (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire front_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output div_type        out_data
   );

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic [XW-1:0] hue_den;

   always_comb begin
      hue_den = {1'b0, in_data.delta, 2'b00} + {2'b00, in_data.delta, 1'b0};
      data_in.hue_rem    = {in_data.hue_x, 8'b0} - {8'b0, in_data.hue_x};
      data_in.hue_den    = {hue_den, 7'b0};
      data_in.hue_q      = '0;
      data_in.sat_rem    = {in_data.delta, 8'b0} - {8'b0, in_data.delta};
      data_in.sat_den    = {in_data.brightness, 7'b0};
      data_in.sat_q      = '0;
      data_in.brightness = in_data.brightness;
      data_in.grey       = in_data.grey;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rhsv_div_step.sv */
// One restoring division stage producing one quotient bit for hue and saturation.
`default_nettype none

module rhsv_div_step
   import rhsv_pkg::*;
   (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire div_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output div_type      out_data
   );

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic    hue_ge;
   logic    sat_ge;

   always_comb begin
      data_in = in_data;
      hue_ge  = in_data.hue_rem >= {1'b0, in_data.hue_den};
      sat_ge  = in_data.sat_rem >= {1'b0, in_data.sat_den};
      if (hue_ge) begin
         data_in.hue_rem = in_data.hue_rem - {1'b0, in_data.hue_den};
      end
      if (sat_ge) begin
         data_in.sat_rem = in_data.sat_rem - {1'b0, in_data.sat_den};
      end
      data_in.hue_q   = {in_data.hue_q[QuotW-2:0], hue_ge};
      data_in.sat_q   = {in_data.sat_q[QuotW-2:0], sat_ge};
      data_in.hue_den = in_data.hue_den >> 1;
      data_in.sat_den = in_data.sat_den >> 1;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_hsv_pixel_unit.sv */
// Top level of the pipelined RGB to HSV pixel converter.
//
// Channel | Direction | Payload
// req_bus | in        | red, green, blue (8 bits each)
// rsp_bus | out       | hue, saturation, brightness (8 bits each)
//
// One pixel is taken per clock while no stall backs up to the input. The pipeline
// is made of the front stage, the dividend stage and eight one-bit divider stages
// that serve hue and saturation side by side. Reset clears every stage valid bit.
// Each stage holds its contents while the next one is full and stalled, so a
// stall backs up stage by stage.
`default_nettype none

module rgb_to_hsv_pixel_unit
   import rhsv_pkg::*;
   (
   input  wire logic   clock,
   input  wire logic   reset,
   rhsv_req_if.sink    req_bus,
   rhsv_rsp_if.source  rsp_bus
   );

   localparam int NumSteps = QuotW;

   pixel_type  pix;
   logic       front_valid;
   logic       front_ready;
   front_type  front_data;
   logic       step_valid [NumSteps+1];
   logic       step_ready [NumSteps+1];
   div_type    step_data  [NumSteps+1];
   logic       rsp_ready;

   assign pix.red   = req_bus.red;
   assign pix.green = req_bus.green;
   assign pix.blue  = req_bus.blue;

   rhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (pix),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   rhsv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (step_valid[0]),
      .out_ready (step_ready[0]),
      .out_data  (step_data[0])
   );

   for (genvar i = 0; i < NumSteps; i++) begin : g_step
      rhsv_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_valid[i]),
         .in_ready  (step_ready[i]),
         .in_data   (step_data[i]),
         .out_valid (step_valid[i+1]),
         .out_ready (step_ready[i+1]),
         .out_data  (step_data[i+1])
      );
   end

   assign rsp_ready             = rsp_bus.ready;
   assign step_ready[NumSteps]  = rsp_ready;
   assign rsp_bus.valid         = step_valid[NumSteps];
   assign rsp_bus.hue           = step_data[NumSteps].grey ? '0 : step_data[NumSteps].hue_q;
   assign rsp_bus.saturation    = step_data[NumSteps].grey ? '0 : step_data[NumSteps].sat_q;
   assign rsp_bus.brightness    = step_data[NumSteps].brightness;

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the pipelined RGB to HSV pixel converter.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rhsv_pkg::*;

   typedef struct packed {
      logic [ChanW-1:0] hue;
      logic [ChanW-1:0] saturation;
      logic [ChanW-1:0] brightness;
   } hsv_pixel_type;

   localparam int DegFull     = 360;
   localparam int ScaleMax    = 255;
   localparam int HoldCycles  = 150;
   localparam int DrainCycles = 20;
   localparam int StallLimit  = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rhsv_req_if req_bus ();
   rhsv_rsp_if rsp_bus ();

   rgb_to_hsv_pixel_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hsv_pixel_type hsv_expected[$];
   int            error_count    = 0;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   logic          hold_off_req   = 1'b0;
   int            hold_count     = 0;
   int            quiet_cycles   = 0;

   always #5 clock = ~clock;

   function automatic hsv_pixel_type convert_pixel(pixel_type px);
      int            r;
      int            g;
      int            b;
      int            top;
      int            bottom;
      int            span;
      int            numer;
      sector_type    sector;
      hsv_pixel_type res;
      r = px.red;
      g = px.green;
      b = px.blue;
      top = r;
      sector = (g >= b) ? SECT_RED_HI : SECT_RED_LO;
      if (g >= top) begin
         top = g;
         sector = SECT_GREEN;
      end
      if (b >= top) begin
         top = b;
         sector = SECT_BLUE;
      end
      bottom = r;
      if (g < bottom) bottom = g;
      if (b < bottom) bottom = b;
      span = top - bottom;
      res = '0;
      res.brightness = ChanW'(top);
      if (top != 0) res.saturation = ChanW'((span * ScaleMax) / top);
      if (span != 0) begin
         case (sector)
            SECT_BLUE:   numer = 240 * span + 60 * (r - g);
            SECT_GREEN:  numer = 120 * span + 60 * (b - r);
            SECT_RED_HI: numer = 60 * (g - b);
            default:     numer = DegFull * span + 60 * (g - b);
         endcase
         if (numer < 0) numer = 0;
         res.hue = ChanW'((numer * ScaleMax) / (span * DegFull));
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [ChanW-1:0] want,
                              input logic [ChanW-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      hsv_pixel_type want;
      pixel_type     px;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (hsv_expected.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transfer, expected none, actual hue %0d sat %0d val %0d",
                        $time, rsp_bus.hue, rsp_bus.saturation, rsp_bus.brightness);
            end else begin
               want = hsv_expected.pop_front();
               check_field("hue", want.hue, rsp_bus.hue);
               check_field("saturation", want.saturation, rsp_bus.saturation);
               check_field("brightness", want.brightness, rsp_bus.brightness);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            px.red   = req_bus.red;
            px.green = req_bus.green;
            px.blue  = req_bus.blue;
            hsv_expected.push_back(convert_pixel(px));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_count    <= 0;
      end else if (hold_off_req && hold_count < HoldCycles) begin
         rsp_bus.ready <= 1'b0;
         hold_count    <= hold_count + 1;
      end else begin
         if (!hold_off_req) hold_count <= 0;
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= StallLimit) begin
            $display("FAILURE");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_pixel(input pixel_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.red   <= px.red;
      req_bus.green <= px.green;
      req_bus.blue  <= px.blue;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_rgb(input int r, input int g, input int b);
      pixel_type px;
      px.red   = ChanW'(r);
      px.green = ChanW'(g);
      px.blue  = ChanW'(b);
      send_pixel(px);
   endtask

   task automatic wait_results();
      req_bus.valid <= 1'b0;
      while (hsv_expected.size() != 0) @(posedge clock);
   endtask

   function automatic pixel_type random_pixel();
      pixel_type px;
      int        peak;
      px = pixel_type'($urandom);
      case ($urandom_range(7))
         4: begin
            px.green = px.red;
            px.blue  = px.red;
         end
         5: begin
            peak = $urandom_range(255);
            px.red   = ChanW'(peak);
            px.green = ChanW'(peak);
            px.blue  = ChanW'(peak);
            case ($urandom_range(2))
               0:       px.red   = ChanW'($urandom_range(peak));
               1:       px.green = ChanW'($urandom_range(peak));
               default: px.blue  = ChanW'($urandom_range(peak));
            endcase
         end
         6: begin
            px.red   = ChanW'($urandom_range(3));
            px.green = ChanW'($urandom_range(3));
            px.blue  = ChanW'($urandom_range(3));
         end
         7: begin
            px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(1) ? 8'hFF : 8'h00;
            px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_rgb(0, 0, 0);
      send_rgb(255, 255, 255);
      send_rgb(128, 128, 128);
      send_rgb(1, 1, 1);
      send_rgb(255, 0, 0);
      send_rgb(0, 255, 0);
      send_rgb(0, 0, 255);
      send_rgb(255, 10, 5);
      send_rgb(255, 0, 1);
      send_rgb(200, 50, 50);
      send_rgb(255, 255, 0);
      send_rgb(0, 255, 255);
      send_rgb(255, 0, 255);
      send_rgb(10, 200, 100);
      send_rgb(100, 10, 200);
      send_rgb(1, 0, 0);
      send_rgb(0, 1, 0);
      send_rgb(0, 0, 1);
      send_rgb(254, 255, 0);
      send_rgb(170, 85, 170);
      send_rgb(85, 170, 85);
      send_rgb(255, 254, 255);
      wait_results();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_pixel(random_pixel());
      wait_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_req  <= 1'b1;
      repeat (40) send_pixel(random_pixel());
      wait_results();
      hold_off_req  <= 1'b0;
   endtask

   task automatic test_sender_pause();
      send_idle_pct  = 0;
      recv_stall_pct = 18;
      repeat (30) send_pixel(random_pixel());
      wait_results();
      send_idle_pct = 18;
      repeat (30) send_pixel(random_pixel());
      wait_results();
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.red   <= '0;
      req_bus.green <= '0;
      req_bus.blue  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(360, 0, 0);
      test_random_traffic(360, 76, 0);
      test_random_traffic(360, 0, 76);
      test_random_traffic(360, 18, 18);
      test_backpressure();
      test_sender_pause();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && hsv_expected.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/rhsv_pkg.sv
hw/rtl/rhsv_req_if.sv
hw/rtl/rhsv_rsp_if.sv
hw/rtl/rhsv_front.sv
hw/rtl/rhsv_prep.sv
hw/rtl/rhsv_div_step.sv
hw/rtl/rgb_to_hsv_pixel_unit.sv
sim/testbench.sv
